@@ hdl/dns_message_stream_parser_macros.svh @@
// assertion macros for the dns message stream parser checks
// each macro expects clk and rst_n in scope
`ifndef DNS_MESSAGE_STREAM_PARSER_MACROS_SVH
`define DNS_MESSAGE_STREAM_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DNSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DNSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dnsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dnsp_pkg
// Types and constants shared by the dns message stream parser files.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    // longest name text accepted, each label counting its length plus one
    localparam int unsigned MAX_NAME_TEXT = 256;

    // label prefix codes
    localparam logic [1:0] PFX_LABEL   = 2'b00;
    localparam logic [1:0] PFX_POINTER = 2'b11;

    // sections
    typedef logic [2:0] section_t;
    localparam section_t SEC_HEADER     = 3'd0;
    localparam section_t SEC_QUESTION   = 3'd1;
    localparam section_t SEC_ADDITIONAL = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ID      = 5'd1,
        PH_FLAGS   = 5'd2,
        PH_QD      = 5'd3,
        PH_AN      = 5'd4,
        PH_NS      = 5'd5,
        PH_AR      = 5'd6,
        PH_NAMELEN = 5'd7,
        PH_PTRLO   = 5'd8,
        PH_LABEL   = 5'd9,
        PH_TYPE    = 5'd10,
        PH_CLASS   = 5'd11,
        PH_TTL     = 5'd12,
        PH_RDLEN   = 5'd13,
        PH_RDATA   = 5'd14
    } phase_t;

    typedef enum logic [4:0] {
        TK_ID        = 5'd0,
        TK_FLAGS     = 5'd1,
        TK_QDCOUNT   = 5'd2,
        TK_ANCOUNT   = 5'd3,
        TK_NSCOUNT   = 5'd4,
        TK_ARCOUNT   = 5'd5,
        TK_LABEL_LEN = 5'd6,
        TK_NAME_BYTE = 5'd7,
        TK_NAME_END  = 5'd8,
        TK_POINTER   = 5'd9,
        TK_TYPE      = 5'd10,
        TK_CLASS     = 5'd11,
        TK_TTL       = 5'd12,
        TK_RDLEN     = 5'd13,
        TK_RDATA     = 5'd14,
        TK_DONE      = 5'd15,
        TK_ERROR     = 5'd16
    } tok_kind_t;

    // one token as it leaves the parser
    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        section_t    section;
        logic [15:0] record_number;
        logic        done;
    } token_t;

endpackage

@@ hdl/dnsp_if.sv @@
// ----------------------------------------------------------------------------
// dnsp_in_if / dnsp_out_if
// Valid/ready channels carrying message bytes in and tokens out.
// ----------------------------------------------------------------------------
interface dnsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface dnsp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] token_value;
    logic [2:0]  section;
    logic [15:0] record_number;
    logic        message_done;

    modport source (output valid, output token_kind, output token_value, output section,
                    output record_number, output message_done, input ready);
    modport sink   (input valid, input token_kind, input token_value, input section,
                    input record_number, input message_done, output ready);
endinterface

@@ hdl/dns_message_stream_parser.sv @@
// ----------------------------------------------------------------------------
// dns_message_stream_parser
// Parses a DNS wire-format message one byte per item into field tokens.
// ----------------------------------------------------------------------------
// byte_ch carries one message byte per item; message_start on an item
// restarts the parse and that byte is the first byte of the id.
// token_ch carries at most one token per input byte: kind, value, section,
// record number and message_done on the final token or on an error.
// The parse state is updated in the cycle a byte is accepted and the token
// sits in the output register from the next cycle.
// Throughput is one byte per cycle unless token_ch stalls: the state update is a
// single pass of combinational logic from the state registers to their next values.
// byte_ch.ready is high whenever the output register is empty or is being
// emptied in this cycle; while the receiver stalls with a token waiting,
// input stops and the token holds.
// After reset the parser is idle and ignores bytes until message_start;
// it goes idle again at the end of a message and after an error token.
// Compression pointers are reported as 14-bit offsets and not followed.
// ----------------------------------------------------------------------------
module dns_message_stream_parser
(
    input  logic              clk,
    input  logic              rst_n,
    dnsp_in_if.sink           byte_ch,
    dnsp_out_if.source        token_ch
);

    // parse state
    dnsp_pkg::phase_t   phase_reg, phase_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [31:0]        acc_reg, acc_next;
    logic [15:0]        entries_reg [4];
    logic [15:0]        entries_next [4];
    dnsp_pkg::section_t sec_reg, sec_next;
    logic [15:0]        idx_reg, idx_next;
    logic [5:0]         lbl_reg, lbl_next;
    logic [8:0]         ntl_reg, ntl_next;
    logic [15:0]        rd_reg, rd_next;

    // output register
    logic               out_valid_reg;
    dnsp_pkg::token_t   tok_reg;

    // effective state after a possible restart
    dnsp_pkg::phase_t   phase_eff;
    logic [2:0]         cnt_eff;
    logic [31:0]        acc_eff;
    logic [15:0]        entries_eff [4];
    dnsp_pkg::section_t sec_eff;
    logic [15:0]        idx_eff;
    logic [8:0]         ntl_eff;

    logic               accept;
    logic               tok_valid;
    dnsp_pkg::token_t   tok;
    logic [7:0]         b;
    logic [31:0]        acc_shift;
    logic [2:0]         cnt_inc;
    logic [2:0]         need;
    logic               field_done;
    logic [3:0]         nz;
    logic [1:0]         cur_i;
    logic [15:0]        ent_dec;
    logic [9:0]         name_sum;

    // first section at or after s (1..4) whose count is non-zero
    function automatic logic [3:0] first_section(input logic [3:0] nzv, input logic [2:0] s);
        logic       found;
        logic [2:0] k_sel;
        found = 1'b0;
        k_sel = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            if (!found && (3'(k) >= s) && nzv[k - 1])
            begin
                found = 1'b1;
                k_sel = 3'(k);
            end
        end
        return {found, k_sel};
    endfunction

    assign byte_ch.ready = !out_valid_reg || token_ch.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign b             = byte_ch.data_byte;

    // restart view of the state
    always_comb
    begin
        if (byte_ch.message_start)
        begin
            phase_eff = dnsp_pkg::PH_ID;
            cnt_eff   = '0;
            acc_eff   = '0;
            sec_eff   = dnsp_pkg::SEC_HEADER;
            idx_eff   = '0;
            ntl_eff   = '0;
            for (int i = 0; i < 4; i++)
            begin
                entries_eff[i] = '0;
            end
        end
        else
        begin
            phase_eff = phase_reg;
            cnt_eff   = cnt_reg;
            acc_eff   = acc_reg;
            sec_eff   = sec_reg;
            idx_eff   = idx_reg;
            ntl_eff   = ntl_reg;
            for (int i = 0; i < 4; i++)
            begin
                entries_eff[i] = entries_reg[i];
            end
        end
    end

    // shared field assembly and entry bookkeeping terms
    always_comb
    begin
        acc_shift = {acc_eff[23:0], b};
        cnt_inc   = cnt_eff + 3'd1;
        need      = (phase_eff == dnsp_pkg::PH_TTL) ? 3'd4 : 3'd2;
        field_done = (cnt_inc >= need);
        for (int i = 0; i < 4; i++)
        begin
            nz[i] = (entries_eff[i] != 16'd0);
        end
        cur_i    = sec_eff[1:0] - 2'd1;
        ent_dec  = entries_eff[cur_i] - 16'd1;
        name_sum = {1'b0, ntl_eff} + {2'b00, b};
    end

    // next state and token
    always_comb
    begin
        logic [3:0] fs;
        logic [3:0] nz_hdr;
        logic       fin;

        phase_next = phase_eff;
        cnt_next   = cnt_eff;
        acc_next   = acc_eff;
        sec_next   = sec_eff;
        idx_next   = idx_eff;
        lbl_next   = lbl_reg;
        ntl_next   = ntl_eff;
        rd_next    = rd_reg;
        for (int i = 0; i < 4; i++)
        begin
            entries_next[i] = entries_eff[i];
        end

        tok_valid         = 1'b0;
        tok.kind          = dnsp_pkg::TK_ID;
        tok.value         = '0;
        tok.section       = sec_eff;
        tok.record_number = idx_eff;
        tok.done          = 1'b0;
        fin               = 1'b0;
        fs                = '0;
        nz_hdr            = nz;

        case (phase_eff)
            dnsp_pkg::PH_ID, dnsp_pkg::PH_FLAGS, dnsp_pkg::PH_QD,
            dnsp_pkg::PH_AN, dnsp_pkg::PH_NS, dnsp_pkg::PH_AR:
            begin
                acc_next = acc_shift;
                cnt_next = field_done ? 3'd0 : cnt_inc;
                if (field_done)
                begin
                    tok_valid = 1'b1;
                    tok.kind  = dnsp_pkg::tok_kind_t'(phase_eff - 5'd1);
                    tok.value = {16'd0, acc_shift[15:0]};
                    if (phase_eff inside {dnsp_pkg::PH_QD, dnsp_pkg::PH_AN,
                                          dnsp_pkg::PH_NS, dnsp_pkg::PH_AR})
                    begin
                        entries_next[2'(phase_eff - dnsp_pkg::PH_QD)] = acc_shift[15:0];
                    end
                    if (phase_eff == dnsp_pkg::PH_AR)
                    begin
                        // enter the first section with entries
                        nz_hdr[3] = (acc_shift[15:0] != 16'd0);
                        fs = first_section(nz_hdr, dnsp_pkg::SEC_QUESTION);
                        if (fs[3])
                        begin
                            sec_next   = fs[2:0];
                            idx_next   = '0;
                            ntl_next   = '0;
                            phase_next = dnsp_pkg::PH_NAMELEN;
                        end
                        else
                        begin
                            phase_next = dnsp_pkg::PH_IDLE;
                            tok.done   = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = dnsp_pkg::phase_t'(phase_eff + 5'd1);
                    end
                end
            end
            dnsp_pkg::PH_NAMELEN:
            begin
                tok_valid = 1'b1;
                if (b == 8'd0)
                begin
                    tok.kind   = dnsp_pkg::TK_NAME_END;
                    phase_next = dnsp_pkg::PH_TYPE;
                end
                else if (b[7:6] == dnsp_pkg::PFX_POINTER)
                begin
                    tok_valid  = 1'b0;
                    acc_next   = {26'd0, b[5:0]};
                    phase_next = dnsp_pkg::PH_PTRLO;
                end
                else if ((b[7:6] != dnsp_pkg::PFX_LABEL) ||
                         (name_sum >= 10'(dnsp_pkg::MAX_NAME_TEXT)))
                begin
                    tok.kind   = dnsp_pkg::TK_ERROR;
                    tok.value  = {24'd0, b};
                    tok.done   = 1'b1;
                    phase_next = dnsp_pkg::PH_IDLE;
                end
                else
                begin
                    tok.kind   = dnsp_pkg::TK_LABEL_LEN;
                    tok.value  = {24'd0, b};
                    lbl_next   = b[5:0];
                    ntl_next   = name_sum[8:0] + 9'd1;
                    phase_next = dnsp_pkg::PH_LABEL;
                end
            end
            dnsp_pkg::PH_PTRLO:
            begin
                tok_valid  = 1'b1;
                tok.kind   = dnsp_pkg::TK_POINTER;
                tok.value  = {18'd0, acc_eff[5:0], b};
                acc_next   = '0;
                phase_next = dnsp_pkg::PH_TYPE;
            end
            dnsp_pkg::PH_LABEL:
            begin
                tok_valid = 1'b1;
                tok.kind  = dnsp_pkg::TK_NAME_BYTE;
                tok.value = {24'd0, b};
                lbl_next  = lbl_reg - 6'd1;
                if (lbl_reg == 6'd1)
                begin
                    phase_next = dnsp_pkg::PH_NAMELEN;
                end
            end
            dnsp_pkg::PH_TYPE, dnsp_pkg::PH_CLASS, dnsp_pkg::PH_TTL, dnsp_pkg::PH_RDLEN:
            begin
                acc_next = acc_shift;
                cnt_next = field_done ? 3'd0 : cnt_inc;
                if (field_done)
                begin
                    tok_valid = 1'b1;
                    tok.value = (phase_eff == dnsp_pkg::PH_TTL) ? acc_shift
                                                                 : {16'd0, acc_shift[15:0]};
                    case (phase_eff)
                        dnsp_pkg::PH_TYPE:
                        begin
                            tok.kind   = dnsp_pkg::TK_TYPE;
                            phase_next = dnsp_pkg::PH_CLASS;
                        end
                        dnsp_pkg::PH_CLASS:
                        begin
                            tok.kind = dnsp_pkg::TK_CLASS;
                            if (sec_eff == dnsp_pkg::SEC_QUESTION)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = dnsp_pkg::PH_TTL;
                            end
                        end
                        dnsp_pkg::PH_TTL:
                        begin
                            tok.kind   = dnsp_pkg::TK_TTL;
                            phase_next = dnsp_pkg::PH_RDLEN;
                        end
                        default:
                        begin
                            tok.kind = dnsp_pkg::TK_RDLEN;
                            rd_next  = acc_shift[15:0];
                            if (acc_shift[15:0] == 16'd0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = dnsp_pkg::PH_RDATA;
                            end
                        end
                    endcase
                end
            end
            dnsp_pkg::PH_RDATA:
            begin
                tok_valid = 1'b1;
                tok.kind  = dnsp_pkg::TK_RDATA;
                tok.value = {24'd0, b};
                rd_next   = rd_reg - 16'd1;
                fin       = (rd_reg == 16'd1);
            end
            default:
            begin
                phase_next = dnsp_pkg::PH_IDLE;
            end
        endcase

        // close the current entry, moving on to the next one or section
        if (fin)
        begin
            entries_next[cur_i] = ent_dec;
            if (ent_dec == 16'd0)
            begin
                fs = first_section(nz, sec_eff + 3'd1);
                if (fs[3])
                begin
                    sec_next   = fs[2:0];
                    idx_next   = '0;
                    ntl_next   = '0;
                    phase_next = dnsp_pkg::PH_NAMELEN;
                end
                else
                begin
                    phase_next = dnsp_pkg::PH_IDLE;
                    tok.done   = 1'b1;
                end
            end
            else
            begin
                idx_next   = idx_eff + 16'd1;
                ntl_next   = '0;
                phase_next = dnsp_pkg::PH_NAMELEN;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dnsp_pkg::PH_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            sec_reg   <= dnsp_pkg::SEC_HEADER;
            idx_reg   <= '0;
            lbl_reg   <= '0;
            ntl_reg   <= '0;
            rd_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            sec_reg   <= sec_next;
            idx_reg   <= idx_next;
            lbl_reg   <= lbl_next;
            ntl_reg   <= ntl_next;
            rd_reg    <= rd_next;
            for (int i = 0; i < 4; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= tok_valid;
        end
        else if (token_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept && tok_valid)
        begin
            tok_reg <= tok;
        end
    end

    assign token_ch.valid         = out_valid_reg;
    assign token_ch.token_kind    = tok_reg.kind;
    assign token_ch.token_value   = tok_reg.value;
    assign token_ch.section       = tok_reg.section;
    assign token_ch.record_number = tok_reg.record_number;
    assign token_ch.message_done  = tok_reg.done;

endmodule

@@ hdl/dnsp_checker.sv @@
// ----------------------------------------------------------------------------
// dnsp_checker
// Port-level checks on the dns message stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_message_stream_parser_macros.svh"

module dnsp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        message_start,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  token_kind,
    input logic [31:0] token_value,
    input logic [2:0]  section,
    input logic [15:0] record_number,
    input logic        message_done
);

    // a stalled token holds
    `DNSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_value) && $stable(message_done), "token changed while stalled")

    // an empty output register never blocks input
    `DNSP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")

    // the first byte of a message never completes a field
    `DNSP_ASSERT_NEXT(a_start_no_token, in_valid && in_ready && message_start, !out_valid, "token on first byte of a message")

    // an error always ends the message
    `DNSP_ASSERT_NOW(a_error_done, out_valid && (token_kind == 5'(dnsp_pkg::TK_ERROR)), message_done, "error token without message_done")

    // header tokens carry section zero and record zero
    `DNSP_ASSERT_NOW(a_header_section, out_valid && (token_kind <= 5'(dnsp_pkg::TK_ARCOUNT)), (section == dnsp_pkg::SEC_HEADER) && (record_number == 16'd0), "header token outside header")

endmodule

bind dns_message_stream_parser dnsp_checker u_dnsp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (byte_ch.valid),
    .in_ready      (byte_ch.ready),
    .message_start (byte_ch.message_start),
    .out_valid     (token_ch.valid),
    .out_ready     (token_ch.ready),
    .token_kind    (token_ch.token_kind),
    .token_value   (token_ch.token_value),
    .section       (token_ch.section),
    .record_number (token_ch.record_number),
    .message_done  (token_ch.message_done)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds DNS messages byte by byte into the stream parser and checks every
// token against a cycle-free model of the parse kept in this module. Directed
// messages cover header extremes, pointers, empty rdata, reserved prefixes,
// over-long names and restarts. Random messages follow, mostly well formed,
// with cut-short messages, stray bytes and random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import dnsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1700;

    logic clk = 1'b0;
    logic rst_n;

    dnsp_in_if  byte_if ();
    dnsp_out_if token_if ();

    dns_message_stream_parser i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_if),
        .token_ch (token_if)
    );

    always #4 clk = ~clk;

    // parse state mirrored from the block
    phase_t      ph;
    logic [2:0]  fcnt;
    logic [31:0] acc;
    logic [15:0] left_cnt [4];
    section_t    cur_sec;
    logic [15:0] rec_idx;
    logic [5:0]  lab_left;
    logic [8:0]  text_len;
    logic [15:0] rd_left;

    token_t pending_tokens [$];
    int     bad_tokens;
    int     sent_items;
    int     cycle_count;
    bit     no_gaps;

    // ---------------------------------------------------------------- model

    function automatic void clear_state();
        ph       = PH_IDLE;
        fcnt     = '0;
        acc      = '0;
        left_cnt = '{default: '0};
        cur_sec  = SEC_HEADER;
        rec_idx  = '0;
        lab_left = '0;
        text_len = '0;
        rd_left  = '0;
    endfunction

    // shift one byte into a multi-byte field, true once it is complete
    function automatic bit take_field(input logic [7:0] b, input int n);
        acc  = {acc[23:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt >= n)
        begin
            fcnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // first section from s on with entries left; true when none remain
    function automatic bit enter_section(input int s);
        for (int k = s; k <= 4; k++)
        begin
            if (left_cnt[k-1] != 0)
            begin
                cur_sec  = section_t'(k);
                rec_idx  = '0;
                text_len = '0;
                ph       = PH_NAMELEN;
                return 1'b0;
            end
        end
        ph = PH_IDLE;
        return 1'b1;
    endfunction

    // close the entry in progress; true when the message is complete
    function automatic bit close_entry();
        int i;
        i = int'(cur_sec) - 1;
        left_cnt[i] = left_cnt[i] - 16'd1;
        if (left_cnt[i] == 0)
            return enter_section(int'(cur_sec) + 1);
        rec_idx  = rec_idx + 16'd1;
        text_len = '0;
        ph       = PH_NAMELEN;
        return 1'b0;
    endfunction

    function automatic token_t make_token(input tok_kind_t kind, input logic [31:0] value);
        token_t t;
        t.kind          = kind;
        t.value         = value;
        t.section       = cur_sec;
        t.record_number = rec_idx;
        t.done          = 1'b0;
        return t;
    endfunction

    // advance the parse by one byte; true when a token comes out
    function automatic bit next_token(input logic [7:0] b, input logic st, output token_t tok);
        tok = '0;
        if (st)
        begin
            clear_state();
            ph = PH_ID;
        end
        case (ph)
            PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR:
            begin
                if (!take_field(b, 2))
                    return 1'b0;
                tok = make_token(tok_kind_t'(int'(ph) - 1), {16'h0, acc[15:0]});
                if (ph >= PH_QD)
                    left_cnt[int'(ph) - int'(PH_QD)] = acc[15:0];
                if (ph == PH_AR)
                    tok.done = enter_section(1);
                else
                    ph = phase_t'(int'(ph) + 1);
                return 1'b1;
            end
            PH_NAMELEN:
            begin
                if (b == 8'h00)
                begin
                    tok = make_token(TK_NAME_END, '0);
                    ph  = PH_TYPE;
                    return 1'b1;
                end
                if (b[7:6] == PFX_POINTER)
                begin
                    acc = {26'h0, b[5:0]};
                    ph  = PH_PTRLO;
                    return 1'b0;
                end
                // reserved prefix or name text at its limit
                if (b[7:6] != PFX_LABEL || int'(text_len) + int'(b) >= MAX_NAME_TEXT)
                begin
                    tok      = make_token(TK_ERROR, {24'h0, b});
                    tok.done = 1'b1;
                    ph       = PH_IDLE;
                    return 1'b1;
                end
                tok      = make_token(TK_LABEL_LEN, {24'h0, b});
                lab_left = b[5:0];
                text_len = text_len + {1'b0, b} + 9'd1;
                ph       = PH_LABEL;
                return 1'b1;
            end
            PH_PTRLO:
            begin
                tok = make_token(TK_POINTER, {18'h0, acc[5:0], b});
                acc = '0;
                ph  = PH_TYPE;
                return 1'b1;
            end
            PH_LABEL:
            begin
                tok      = make_token(TK_NAME_BYTE, {24'h0, b});
                lab_left = lab_left - 6'd1;
                if (lab_left == 0)
                    ph = PH_NAMELEN;
                return 1'b1;
            end
            PH_TYPE:
            begin
                if (!take_field(b, 2))
                    return 1'b0;
                tok = make_token(TK_TYPE, {16'h0, acc[15:0]});
                ph  = PH_CLASS;
                return 1'b1;
            end
            PH_CLASS:
            begin
                if (!take_field(b, 2))
                    return 1'b0;
                tok = make_token(TK_CLASS, {16'h0, acc[15:0]});
                if (cur_sec == SEC_QUESTION)
                    tok.done = close_entry();
                else
                    ph = PH_TTL;
                return 1'b1;
            end
            PH_TTL:
            begin
                if (!take_field(b, 4))
                    return 1'b0;
                tok = make_token(TK_TTL, acc);
                ph  = PH_RDLEN;
                return 1'b1;
            end
            PH_RDLEN:
            begin
                if (!take_field(b, 2))
                    return 1'b0;
                tok     = make_token(TK_RDLEN, {16'h0, acc[15:0]});
                rd_left = acc[15:0];
                if (rd_left == 0)
                    tok.done = close_entry();
                else
                    ph = PH_RDATA;
                return 1'b1;
            end
            PH_RDATA:
            begin
                tok     = make_token(TK_RDATA, {24'h0, b});
                rd_left = rd_left - 16'd1;
                if (rd_left == 0)
                    tok.done = close_entry();
                return 1'b1;
            end
            default:
            begin
                ph = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------ stimulus

    // offer one byte, with random idle cycles first, and wait for acceptance
    task automatic send_byte(input logic [7:0] b, input logic st);
        token_t tok;
        while (!no_gaps && $urandom_range(0, 99) < 15)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid         <= 1'b1;
        byte_if.data_byte     <= b;
        byte_if.message_start <= st;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        sent_items++;
        if (next_token(b, st, tok))
            pending_tokens.push_back(tok);
    endtask

    task automatic send_field(input int n, input logic [31:0] v);
        for (int i = n - 1; i >= 0; i--)
            send_byte(v[8*i +: 8], 1'b0);
    endtask

    task automatic send_header(input logic [15:0] id, input logic [15:0] flags,
                               input logic [15:0] qd, input logic [15:0] an,
                               input logic [15:0] ns, input logic [15:0] ar);
        send_byte(id[15:8], 1'b1);
        send_byte(id[7:0], 1'b0);
        send_field(2, flags);
        send_field(2, qd);
        send_field(2, an);
        send_field(2, ns);
        send_field(2, ar);
    endtask

    task automatic send_label(input int len);
        send_byte(8'(len), 1'b0);
        repeat (len)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // stop is set when the name ends the message in an error
    task automatic send_name(output bit stop);
        int mode;
        int len;
        int text;
        stop = 1'b0;
        text = 0;
        mode = $urandom_range(0, 99);
        // long labels until the name text overflows
        if (mode < 3)
        begin
            len = $urandom_range(30, 63);
            while (text + len < MAX_NAME_TEXT)
            begin
                send_label(len);
                text += len + 1;
                len = $urandom_range(1, 63);
            end
            send_byte(8'(len), 1'b0);
            stop = 1'b1;
            return;
        end
        repeat ($urandom_range(0, 3))
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 12);
            send_label(len);
        end
        mode = $urandom_range(0, 99);
        if (mode < 70)
            send_byte(8'h00, 1'b0);
        else if (mode < 95)
        begin
            send_byte({PFX_POINTER, 6'($urandom_range(0, 63))}, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            send_byte(8'($urandom_range(8'h40, 8'hBF)), 1'b0);
            stop = 1'b1;
        end
    endtask

    // one question or resource record; stop when the message is cut here
    task automatic send_entry(input bit question, output bit stop);
        logic [15:0] rdlen;
        int          pick;
        send_name(stop);
        if (stop)
            return;
        send_field(2, $urandom());
        send_field(2, $urandom());
        if (question)
            return;
        send_field(4, $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 15)
            rdlen = '0;
        else if (pick < 97)
            rdlen = 16'($urandom_range(1, 8));
        else
            rdlen = 16'($urandom());
        send_field(2, {16'h0, rdlen});
        // huge rdata: send a few bytes and let a restart cut it short
        if (rdlen > 16)
        begin
            repeat ($urandom_range(0, 4))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            stop = 1'b1;
            return;
        end
        repeat (rdlen)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_message();
        logic [15:0] counts [4];
        bit          huge;
        bit          stop;
        int          entries;
        // a header cut short by the next start
        if ($urandom_range(0, 99) < 2)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 10))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        huge = ($urandom_range(0, 99) < 4);
        if (huge)
        begin
            foreach (counts[k])
                counts[k] = 16'($urandom());
        end
        else
        begin
            counts[0] = 16'($urandom_range(0, 2));
            counts[1] = 16'($urandom_range(0, 3));
            counts[2] = 16'($urandom_range(0, 1));
            counts[3] = 16'($urandom_range(0, 2));
        end
        send_header(16'($urandom()), 16'($urandom()), counts[0], counts[1], counts[2],
                    counts[3]);
        stop    = 1'b0;
        entries = 0;
        for (int s = 0; s < 4 && !stop; s++)
        begin
            for (int e = 0; e < counts[s] && !stop; e++)
            begin
                if (huge && entries >= 3)
                    stop = 1'b1;
                else
                    send_entry(s == 0, stop);
                entries++;
            end
        end
        // stray bytes while the parser sits idle
        if (ph == PH_IDLE)
        begin
            repeat ($urandom_range(0, 2))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // hold input off until every token has come out
    task automatic wait_for_drain();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------ tests

    task automatic test_ignored_bytes();
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // restart inside the flags, then a message with all counts zero
    task automatic test_empty_message();
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_header(16'hFFFF, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
    endtask

    // pointer after a label in a question, root name, empty rdata, max offset
    task automatic test_record_fields();
        send_header(16'h0000, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd1);
        send_label(1);
        send_byte({PFX_POINTER, 6'h00}, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_field(2, 32'hFFFF);
        send_field(2, 32'h0000);
        send_byte(8'h00, 1'b0);
        send_field(2, 32'h0001);
        send_field(2, 32'h0001);
        send_field(4, 32'hFFFF_FFFF);
        send_field(2, 32'h0000);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_field(2, 32'h00FF);
        send_field(2, 32'hFF00);
        send_field(4, 32'h0000_0000);
        send_field(2, 32'h0001);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_reserved_prefix();
        send_header(16'hAAAA, 16'h5555, 16'd1, 16'd0, 16'd0, 16'd0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h80, 1'b0);
        send_header(16'h5555, 16'hAAAA, 16'd0, 16'd1, 16'd0, 16'd0);
        send_byte(8'hBF, 1'b0);
    endtask

    // name text reaching the limit exactly
    task automatic test_name_too_long();
        send_header(16'h0F0F, 16'hF0F0, 16'd1, 16'd0, 16'd0, 16'd0);
        repeat (3)
            send_label(63);
        send_label(62);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic test_random_messages();
        int msgs;
        msgs = 0;
        while (sent_items < ITEM_TARGET)
        begin
            // a long stretch with no idling on either side
            no_gaps = (sent_items >= 800 && sent_items < 1100);
            send_message();
            msgs++;
            if (msgs % 5 == 0)
                wait_for_drain();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------ checking

    always @(posedge clk)
    begin : check_tokens
        token_t exp;
        if (rst_n && token_if.valid && token_if.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token kind %0d value %h section %0d record %0d",
                         $time, token_if.token_kind, token_if.token_value,
                         token_if.section, token_if.record_number);
                bad_tokens++;
            end
            else
            begin
                exp = pending_tokens.pop_front();
                if (token_if.token_kind !== exp.kind || token_if.token_value !== exp.value ||
                    token_if.section !== exp.section ||
                    token_if.record_number !== exp.record_number ||
                    token_if.message_done !== exp.done)
                begin
                    $display("%0t: expected kind %0d value %h section %0d record %0d done %0d",
                             $time, exp.kind, exp.value, exp.section, exp.record_number,
                             exp.done);
                    $display("%0t: actual   kind %0d value %h section %0d record %0d done %0d",
                             $time, token_if.token_kind, token_if.token_value,
                             token_if.section, token_if.record_number,
                             token_if.message_done);
                    bad_tokens++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        token_if.ready <= no_gaps || ($urandom_range(0, 99) >= 15);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clear_state();
        bad_tokens            = 0;
        sent_items            = 0;
        cycle_count           = 0;
        no_gaps               = 1'b0;
        rst_n                 <= 1'b0;
        byte_if.valid         <= 1'b0;
        byte_if.data_byte     <= '0;
        byte_if.message_start <= 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_bytes();
        test_empty_message();
        test_record_fields();
        wait_for_drain();
        test_reserved_prefix();
        test_name_too_long();
        test_random_messages();

        wait_for_drain();
        repeat (10)
            @(posedge clk);
        if (bad_tokens == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
